### rtl/tdnc_pkg.sv
// Shared widths, divisor constants and handshake structs for the
// trial-division classifier. No dependencies.
package tdnc_pkg;

  localparam int unsigned ValueWidth = 32;
  // Trial divisors never pass sqrt(2^(ValueWidth-1)) + 2.
  localparam int unsigned DivWidth   = ValueWidth / 2 + 2;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);

  localparam logic [ValueWidth-1:0] Div7  = ValueWidth'(7);
  localparam logic [ValueWidth-1:0] Div11 = ValueWidth'(11);
  localparam logic [ValueWidth-1:0] Div13 = ValueWidth'(13);
  localparam logic [ValueWidth-1:0] Two   = ValueWidth'(2);

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] dividend;
    logic [ValueWidth-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                  done;
    logic [ValueWidth-1:0] rem;
  } rem_rsp_t;

endpackage

### rtl/tdnc_rem_unit.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on tdnc_pkg.
module tdnc_rem_unit
  import tdnc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [ValueWidth-1:0] rem_q;
  logic [ValueWidth-1:0] rem_d;
  logic [ValueWidth-1:0] shift_q;
  logic [ValueWidth-1:0] divisor_q;
  logic [ValueWidth:0]   trial;
  logic [ValueWidth:0]   diff;

  assign trial = {rem_q, shift_q[ValueWidth-1]};
  assign diff  = trial - {1'b0, divisor_q};
  // borrow out means the partial remainder stays
  assign rem_d = diff[ValueWidth] ? trial[ValueWidth-1:0] : diff[ValueWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntWidth'(ValueWidth - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      shift_q   <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[ValueWidth-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/trial_division_number_classifier.sv
// Top level: sequencer around the shared serial remainder unit.
// Depends on tdnc_pkg and tdnc_rem_unit.
//
// Usage: one signed word enters on in_valid_i/in_ready_o (value_i) and
// one result word of four flags leaves on out_valid_o/out_ready_i.
// in_ready_o is high only while the block is idle; one word is in work
// at a time. Zero or negative words give not_positive alone and come out
// in the cycle after acceptance.
// For a positive word the remainder unit is run for 7, 11, 13 (stopping at
// the first that divides) and then, for odd words above 3, for odd divisors
// 3, 5, 7... while d*d stays within the word, stopping at the first that
// divides. Each remainder is one serial run of the shared unit, one
// divisor at a time; the worst case, a 31-bit prime, needs about 23170
// trial divisors.
// The result is held in registers with out_valid_o high until taken; a
// stalled receiver simply keeps the block busy. Reset returns it to idle
// with no result pending.
module trial_division_number_classifier
  import tdnc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         divisible_7_11_13_o,
  output logic                         is_even_o,
  output logic                         is_prime_o,
  output logic                         not_positive_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_7,
    PH_11,
    PH_13,
    PH_TRIAL
  } phase_e;

  state_e                state_q;
  phase_e                phase_q;
  logic [ValueWidth-1:0] n_q;
  logic [DivWidth-1:0]   d_q;
  logic [ValueWidth-1:0] sq_q;
  logic [ValueWidth-1:0] sq_d;
  logic                  div_q;
  logic                  even_q;
  logic                  prime_q;
  logic                  nonpos_q;
  logic                  trial_q;
  logic                  sq_over;
  logic                  rem_zero;
  logic [ValueWidth-1:0] vin;
  rem_req_t              req;
  rem_rsp_t              rsp;

  assign vin      = value_i;
  assign sq_over  = sq_q > n_q;
  assign rem_zero = rsp.rem == '0;
  // (d+2)^2 = d^2 + 4d + 4
  assign sq_d     = sq_q + ValueWidth'({d_q, 2'b00}) + ValueWidth'(4);

  always_comb begin
    req.start    = (state_q == ST_START) && !((phase_q == PH_TRIAL) && sq_over);
    req.dividend = n_q;
    case (phase_q)
      PH_7:    req.divisor = Div7;
      PH_11:   req.divisor = Div11;
      PH_13:   req.divisor = Div13;
      default: req.divisor = ValueWidth'(d_q);
    endcase
  end

  tdnc_rem_unit u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_7;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q      <= vin;
            div_q    <= 1'b0;
            d_q      <= DivWidth'(3);
            sq_q     <= ValueWidth'(9);
            phase_q  <= PH_7;
            if (vin == '0 || vin[ValueWidth-1]) begin
              even_q   <= 1'b0;
              prime_q  <= 1'b0;
              nonpos_q <= 1'b1;
              trial_q  <= 1'b0;
              state_q  <= ST_OUT;
            end else begin
              even_q   <= ~vin[0];
              prime_q  <= (vin == Two) || (vin == ValueWidth'(3));
              nonpos_q <= 1'b0;
              trial_q  <= vin[0] && (vin > ValueWidth'(3));
              state_q  <= ST_START;
            end
          end
        end
        ST_START: begin
          if ((phase_q == PH_TRIAL) && sq_over) begin
            prime_q <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (rsp.done) begin
            case (phase_q)
              PH_7, PH_11, PH_13: begin
                // first hit among 7, 11, 13 settles the flag
                if (rem_zero || phase_q == PH_13) begin
                  div_q <= div_q | rem_zero;
                  if (trial_q) begin
                    phase_q <= PH_TRIAL;
                    state_q <= ST_START;
                  end else begin
                    state_q <= ST_OUT;
                  end
                end else begin
                  phase_q <= (phase_q == PH_7) ? PH_11 : PH_13;
                  state_q <= ST_START;
                end
              end
              default: begin
                if (rem_zero) begin
                  state_q <= ST_OUT;
                end else begin
                  d_q     <= d_q + DivWidth'(2);
                  sq_q    <= sq_d;
                  state_q <= ST_START;
                end
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o          = state_q == ST_IDLE;
  assign out_valid_o         = state_q == ST_OUT;
  assign divisible_7_11_13_o = div_q;
  assign is_even_o           = even_q;
  assign is_prime_o          = prime_q;
  assign not_positive_o      = nonpos_q;

endmodule
